### src/fla_pkg.sv
package fla_pkg;

	localparam int POOL_SIZE = 32;
	localparam int SLOT_W    = $clog2(POOL_SIZE);
	localparam int CNT_W     = $clog2(POOL_SIZE + 1);
	localparam int NUM_W     = 8;
	localparam int STAT_W    = 3;
	localparam int IDX_W     = 5;

	localparam logic OP_ALLOC   = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
	localparam logic [STAT_W-1:0] ST_EXHAUSTED = 3'd1;
	localparam logic [STAT_W-1:0] ST_RANGE     = 3'd2;
	localparam logic [STAT_W-1:0] ST_NONE_USED = 3'd3;
	localparam logic [STAT_W-1:0] ST_NOT_USED  = 3'd4;

	typedef struct packed {
		logic             operation;
		logic [NUM_W-1:0] slot_number;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [IDX_W-1:0]  slot_index;
	} rsp_t;

	typedef struct packed {
		logic push;
		logic pop;
	} stack_ctl_t;

endpackage

### src/free_list_slot_allocator_core.sv
// Channel   Handshake        Payload           Direction
// request   start / busy     req   (req_t)     in
// result    done strobe      rsp   (rsp_t)     out
//
// One request per cycle; busy is tied low, so every request is taken when start is high.
// The result shows in the cycle after the transfer, on done, for exactly one cycle.
// The free stack is a chain of cells shifting by one per push or pop; the top cell
// and the in-use bitmap set the cycle.
// Reset: stack holds 0..POOL_SIZE-1 with 0 on top, all marks clear, no clearing pass.
// The receiver cannot stall; results are never held.
module free_list_slot_allocator_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  fla_pkg::req_t req,
	output logic          done,
	output fla_pkg::rsp_t rsp
);
	import fla_pkg::*;

	localparam logic [NUM_W:0] POOL_LIM  = (NUM_W+1)'(POOL_SIZE);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(POOL_SIZE);

	logic                 take;
	stack_ctl_t           ctl;
	logic [SLOT_W-1:0]    top;
	logic [SLOT_W-1:0]    rel_slot;
	logic [CNT_W-1:0]     count_q;
	logic [POOL_SIZE-1:0] in_use_q;
	logic                 done_q;
	rsp_t                 rsp_q;
	rsp_t                 rsp_d;

	assign take     = start && !busy;
	assign busy     = 1'b0;
	assign rel_slot = req.slot_number[SLOT_W-1:0];

	always_comb begin
		ctl   = '0;
		rsp_d = '{status: ST_OK, slot_index: '0};
		if (req.operation == OP_ALLOC) begin
			if (count_q == '0) begin
				rsp_d.status = ST_EXHAUSTED;
			end else begin
				ctl.pop          = take;
				rsp_d.slot_index = IDX_W'(top);
			end
		end else begin
			priority if ({1'b0, req.slot_number} >= POOL_LIM) begin
				rsp_d.status = ST_RANGE;
			end else if (count_q == CNT_FULL) begin
				rsp_d.status = ST_NONE_USED;
			end else if (!in_use_q[rel_slot]) begin
				rsp_d.status = ST_NOT_USED;
			end else begin
				ctl.push         = take;
				rsp_d.slot_index = IDX_W'(rel_slot);
			end
		end
	end

	fla_stack u_stack (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.push_data(rel_slot),
		.top      (top)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= CNT_FULL;
			in_use_q <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= take;
			if (ctl.pop) begin
				count_q       <= count_q - CNT_W'(1);
				in_use_q[top] <= 1'b1;
			end else if (ctl.push) begin
				count_q            <= count_q + CNT_W'(1);
				in_use_q[rel_slot] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rsp_q <= rsp_d;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

### src/fla_cell.sv
module fla_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  fla_pkg::stack_ctl_t        ctl,
	input  logic [fla_pkg::SLOT_W-1:0] rst_val,
	input  logic [fla_pkg::SLOT_W-1:0] from_up,
	input  logic [fla_pkg::SLOT_W-1:0] from_down,
	output logic [fla_pkg::SLOT_W-1:0] val
);
	import fla_pkg::*;

	logic [SLOT_W-1:0] val_q;

	// push moves everything one cell deeper, pop pulls one cell toward the top
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= rst_val;
		end else if (ctl.push) begin
			val_q <= from_up;
		end else if (ctl.pop) begin
			val_q <= from_down;
		end
	end

	assign val = val_q;

endmodule

### src/fla_stack.sv
module fla_stack (
	input  logic                       clk,
	input  logic                       arst_n,
	input  fla_pkg::stack_ctl_t        ctl,
	input  logic [fla_pkg::SLOT_W-1:0] push_data,
	output logic [fla_pkg::SLOT_W-1:0] top
);
	import fla_pkg::*;

	logic [SLOT_W-1:0] vals [POOL_SIZE];

	for (genvar i = 0; i < POOL_SIZE; i++) begin : g_cell
		logic [SLOT_W-1:0] up_d;
		logic [SLOT_W-1:0] down_d;

		if (i == 0) begin : g_top
			assign up_d = push_data;
		end else begin : g_mid
			assign up_d = vals[i-1];
		end

		// bottom cell holds its value on pop; it is never read while stale
		if (i == POOL_SIZE - 1) begin : g_bot
			assign down_d = vals[i];
		end else begin : g_inner
			assign down_d = vals[i+1];
		end

		fla_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.rst_val  (SLOT_W'(i)),
			.from_up  (up_d),
			.from_down(down_d),
			.val      (vals[i])
		);
	end

	assign top = vals[0];

endmodule

### src/fla_checker.sv
module fla_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input fla_pkg::req_t req,
	input logic          done,
	input fla_pkg::rsp_t rsp
);
	import fla_pkg::*;

	// every transfer yields exactly one result in the next cycle
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> done)
		else $error("transfer without a result");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |=> !done)
		else $error("result without a transfer");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status != ST_OK) |-> rsp.slot_index == '0)
		else $error("error result carries a slot");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status == ST_RANGE) |->
			($past(req.operation) == OP_RELEASE &&
			 {1'b0, $past(req.slot_number)} >= (NUM_W+1)'(POOL_SIZE)))
		else $error("range error on a valid request");

endmodule

bind free_list_slot_allocator_core fla_checker u_fla_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.req   (req),
	.done  (done),
	.rsp   (rsp)
);
